### design/ctps_pkg.sv
// Shared types and constants for the circle tangent point select pipeline.
package ctps_pkg;

    localparam int SQ_STAGES  = 34;
    localparam int DIV_STAGES = 34;
    localparam int LANES      = 4;

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;
    localparam logic [33:0]        Q_CAP   = 34'h2_0000_0000;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               nx;
        logic               ny;
        logic               in_circle;
        logic               at_center;
    } t_ctx;

    typedef struct packed {
        t_ctx        ctx;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [65:0] d;
        logic [61:0] r2;
        logic [63:0] rax;
        logic [63:0] ray;
    } t_sq_pass;

    typedef struct packed {
        t_sq_pass    p;
        logic [67:0] rad;
        logic [36:0] rem;
        logic [33:0] root;
    } t_sq;

    typedef struct packed {
        t_ctx                    ctx;
        logic [99:0]             dsh;
        logic [LANES-1:0][99:0]  rem;
        logic [LANES-1:0][33:0]  q;
        logic [LANES-1:0]        over;
        logic [LANES-1:0]        neg;
    } t_div;

endpackage

### design/ctps_mul.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module ctps_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[31:0]};
            r_p01 <= {32'b0, i_a[31:0]}  * {32'b0, i_b[63:32]};
            r_p10 <= {32'b0, i_a[63:32]} * {32'b0, i_b[31:0]};
            r_p11 <= {32'b0, i_a[63:32]} * {32'b0, i_b[63:32]};
            r_p   <= {64'b0, r_p00} + {32'b0, r_p01, 32'b0}
                   + {32'b0, r_p10, 32'b0} + {r_p11, 64'b0};
        end
    end

    assign o_p = r_p;
endmodule

### design/ctps_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module ctps_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  ctps_pkg::t_sq i_d,
    output logic         o_valid,
    output ctps_pkg::t_sq o_d
);
    import ctps_pkg::*;

    logic        r_v;
    t_sq         r_d;
    t_sq         n_d;
    logic [36:0] w_rem2;
    logic [36:0] w_trial;
    logic        w_ge;

    always_comb begin
        w_rem2  = {i_d.rem[34:0], i_d.rad[67:66]};
        w_trial = {1'b0, i_d.root, 2'b01};
        w_ge    = w_rem2 >= w_trial;
        n_d      = i_d;
        n_d.rem  = w_ge ? (w_rem2 - w_trial) : w_rem2;
        n_d.root = {i_d.root[32:0], w_ge};
        n_d.rad  = {i_d.rad[65:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_d     = r_d;
endmodule

### design/ctps_div_cell.sv
// One quotient-bit cell of the four-lane restoring divider.
module ctps_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  ctps_pkg::t_div i_d,
    output logic          o_valid,
    output ctps_pkg::t_div o_d
);
    import ctps_pkg::*;

    logic             r_v;
    t_div             r_d;
    t_div             n_d;
    logic [LANES-1:0] w_ge;

    always_comb begin
        n_d = i_d;
        for (int l = 0; l < LANES; l++) begin
            w_ge[l]    = i_d.rem[l] >= i_d.dsh;
            n_d.rem[l] = w_ge[l] ? (i_d.rem[l] - i_d.dsh) : i_d.rem[l];
            n_d.q[l]   = {i_d.q[l][32:0], w_ge[l]};
        end
        n_d.dsh = {1'b0, i_d.dsh[99:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_d     = r_d;
endmodule

### design/circle_tangent_point_select.sv
// Top level: pipelined tangent point computation and nearest-tangent selection.
//
//   channel | handshake                 | payload
//   input   | i_in_valid / o_in_ready   | start, center, radius, reference point
//   output  | o_out_valid / i_out_ready | tangent point, start_inside, start_at_center
//
// One transaction enters per cycle while the output is not stalled.
// The pipeline holds the 34-cell square root chain and the 34-cell divider chain.
// Reset clears only the stage valid bits.
// A stalled output freezes the whole pipeline, bubbles included.
module circle_tangent_point_select (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic        [30:0] i_circle_radius,
    input  logic signed [31:0] i_ref_x,
    input  logic signed [31:0] i_ref_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_tangent_x,
    output logic signed [31:0] o_tangent_y,
    output logic               o_start_inside,
    output logic               o_start_at_center
);
    import ctps_pkg::*;

    logic w_en;

    function automatic logic [98:0] sm_sum(input logic na, input logic [97:0] ma,
                                           input logic nb, input logic [97:0] mb);
        logic [98:0] res;
        if (na == nb) begin
            res = {na, ma + mb};
        end else if (ma >= mb) begin
            res = {na, ma - mb};
        end else begin
            res = {nb, mb - ma};
        end
        return res;
    endfunction

    function automatic logic signed [31:0] place(input logic signed [31:0] c,
                                                 input logic neg, input logic [33:0] q,
                                                 input logic over);
        logic [33:0]        qm;
        logic signed [34:0] v;
        logic signed [31:0] res;
        qm = (over || (q[33] && (|q[32:0]))) ? Q_CAP : q;
        v  = neg ? ({{3{c[31]}}, c} - $signed({1'b0, qm}))
                 : ({{3{c[31]}}, c} + $signed({1'b0, qm}));
        if (v > SAT_MAX) begin
            res = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // stage A: differences
    logic signed [32:0] w_x, w_y;
    logic               r_a_v;
    t_ctx               r_a_ctx;
    logic [32:0]        r_a_ax, r_a_ay;
    logic [30:0]        r_a_r;

    assign w_x = {i_start_x[31], i_start_x} - {i_center_x[31], i_center_x};
    assign w_y = {i_start_y[31], i_start_y} - {i_center_y[31], i_center_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ctx.cx        <= i_center_x;
            r_a_ctx.cy        <= i_center_y;
            r_a_ctx.px        <= i_ref_x;
            r_a_ctx.py        <= i_ref_y;
            r_a_ctx.nx        <= w_x[32];
            r_a_ctx.ny        <= w_y[32];
            r_a_ctx.in_circle <= 1'b0;
            r_a_ctx.at_center <= (w_x == '0) && (w_y == '0);
            r_a_ax            <= w_x[32] ? 33'(-w_x) : 33'(w_x);
            r_a_ay            <= w_y[32] ? 33'(-w_y) : 33'(w_y);
            r_a_r             <= i_circle_radius;
        end
    end

    // first multiplier group
    logic [127:0] w_axx, w_ayy, w_rr, w_rax, w_ray;

    ctps_mul u_mul_axx (.i_clk, .i_en(w_en), .i_a(64'(r_a_ax)), .i_b(64'(r_a_ax)), .o_p(w_axx));
    ctps_mul u_mul_ayy (.i_clk, .i_en(w_en), .i_a(64'(r_a_ay)), .i_b(64'(r_a_ay)), .o_p(w_ayy));
    ctps_mul u_mul_rr  (.i_clk, .i_en(w_en), .i_a(64'(r_a_r)),  .i_b(64'(r_a_r)),  .o_p(w_rr));
    ctps_mul u_mul_rax (.i_clk, .i_en(w_en), .i_a(64'(r_a_r)),  .i_b(64'(r_a_ax)), .o_p(w_rax));
    ctps_mul u_mul_ray (.i_clk, .i_en(w_en), .i_a(64'(r_a_r)),  .i_b(64'(r_a_ay)), .o_p(w_ray));

    logic        r_b1_v, r_b2_v;
    t_ctx        r_b1_ctx, r_b2_ctx;
    logic [32:0] r_b1_ax, r_b1_ay, r_b2_ax, r_b2_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
        end else if (w_en) begin
            r_b1_v <= r_a_v;
            r_b2_v <= r_b1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_ctx <= r_a_ctx;
            r_b1_ax  <= r_a_ax;
            r_b1_ay  <= r_a_ay;
            r_b2_ctx <= r_b1_ctx;
            r_b2_ax  <= r_b1_ax;
            r_b2_ay  <= r_b1_ay;
        end
    end

    // stage C: squared distance, inside test, root input
    logic [65:0] w_d;
    logic        w_inside;
    t_sq         w_sq_in;

    always_comb begin
        w_d      = w_axx[65:0] + w_ayy[65:0];
        w_inside = w_d < {4'b0, w_rr[61:0]};
        w_sq_in.p.ctx           = r_b2_ctx;
        w_sq_in.p.ctx.in_circle = w_inside;
        w_sq_in.p.ax            = r_b2_ax;
        w_sq_in.p.ay            = r_b2_ay;
        w_sq_in.p.d             = w_d;
        w_sq_in.p.r2            = w_rr[61:0];
        w_sq_in.p.rax           = w_rax[63:0];
        w_sq_in.p.ray           = w_ray[63:0];
        w_sq_in.rad             = w_inside ? '0 : {2'b00, w_d - {4'b0, w_rr[61:0]}};
        w_sq_in.rem             = '0;
        w_sq_in.root            = '0;
    end

    logic r_c_v;
    t_sq  r_c_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sq <= w_sq_in;
        end
    end

    // square root chain
    logic [SQ_STAGES:0] w_sq_v;
    t_sq                w_sq [SQ_STAGES+1];

    assign w_sq_v[0] = r_c_v;
    assign w_sq[0]   = r_c_sq;

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
        ctps_sqrt_cell u_cell (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_valid(w_sq_v[g]), .i_d(w_sq[g]),
            .o_valid(w_sq_v[g+1]), .o_d(w_sq[g+1])
        );
    end

    // second multiplier group
    t_sq_pass     w_sp;
    logic [33:0]  w_k;
    logic [127:0] w_ta, w_tb, w_tc, w_te;

    assign w_sp = w_sq[SQ_STAGES].p;
    assign w_k  = w_sq[SQ_STAGES].root;

    ctps_mul u_mul_ta (.i_clk, .i_en(w_en), .i_a(64'(w_sp.r2)), .i_b(64'(w_sp.ax)), .o_p(w_ta));
    ctps_mul u_mul_tb (.i_clk, .i_en(w_en), .i_a(w_sp.ray),     .i_b(64'(w_k)),     .o_p(w_tb));
    ctps_mul u_mul_tc (.i_clk, .i_en(w_en), .i_a(64'(w_sp.r2)), .i_b(64'(w_sp.ay)), .o_p(w_tc));
    ctps_mul u_mul_te (.i_clk, .i_en(w_en), .i_a(w_sp.rax),     .i_b(64'(w_k)),     .o_p(w_te));

    logic        r_e1_v, r_e2_v;
    t_ctx        r_e1_ctx, r_e2_ctx;
    logic [65:0] r_e1_d, r_e2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
        end else if (w_en) begin
            r_e1_v <= w_sq_v[SQ_STAGES];
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_ctx <= w_sp.ctx;
            r_e1_d   <= w_sp.d;
            r_e2_ctx <= r_e1_ctx;
            r_e2_d   <= r_e1_d;
        end
    end

    // stage D: signed numerators
    logic                   r_n_v;
    t_ctx                   r_n_ctx;
    logic [65:0]            r_n_d;
    logic [LANES-1:0][98:0] r_n_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (w_en) begin
            r_n_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n_ctx    <= r_e2_ctx;
            r_n_d      <= r_e2_d;
            r_n_num[0] <= sm_sum(r_e2_ctx.nx, w_ta[97:0], r_e2_ctx.ny, w_tb[97:0]);
            r_n_num[1] <= sm_sum(r_e2_ctx.ny, w_tc[97:0], !r_e2_ctx.nx, w_te[97:0]);
            r_n_num[2] <= sm_sum(r_e2_ctx.nx, w_ta[97:0], !r_e2_ctx.ny, w_tb[97:0]);
            r_n_num[3] <= sm_sum(r_e2_ctx.ny, w_tc[97:0], r_e2_ctx.nx, w_te[97:0]);
        end
    end

    // stage E: divider setup and overflow test
    logic r_dv_v;
    t_div r_dv;
    t_div w_dv_in;

    always_comb begin
        w_dv_in.ctx = r_n_ctx;
        w_dv_in.dsh = {1'b0, r_n_d, 33'b0};
        for (int l = 0; l < LANES; l++) begin
            w_dv_in.rem[l]  = {2'b0, r_n_num[l][97:0]};
            w_dv_in.q[l]    = '0;
            w_dv_in.over[l] = {2'b0, r_n_num[l][97:0]} >= {r_n_d, 34'b0};
            w_dv_in.neg[l]  = r_n_num[l][98];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v <= 1'b0;
        end else if (w_en) begin
            r_dv_v <= r_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv <= w_dv_in;
        end
    end

    // divider chain
    logic [DIV_STAGES:0] w_dv_v;
    t_div                w_dv [DIV_STAGES+1];

    assign w_dv_v[0] = r_dv_v;
    assign w_dv[0]   = r_dv;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        ctps_div_cell u_cell (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_valid(w_dv_v[g]), .i_d(w_dv[g]),
            .o_valid(w_dv_v[g+1]), .o_d(w_dv[g+1])
        );
    end

    // stage F: candidates with saturation
    t_div               w_dq;
    logic               r_f_v;
    t_ctx               r_f_ctx;
    logic signed [31:0] r_f_x1, r_f_y1, r_f_x2, r_f_y2;

    assign w_dq = w_dv[DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_dv_v[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_ctx <= w_dq.ctx;
            r_f_x1  <= place(w_dq.ctx.cx, w_dq.neg[0], w_dq.q[0], w_dq.over[0]);
            r_f_y1  <= place(w_dq.ctx.cy, w_dq.neg[1], w_dq.q[1], w_dq.over[1]);
            r_f_x2  <= place(w_dq.ctx.cx, w_dq.neg[2], w_dq.q[2], w_dq.over[2]);
            r_f_y2  <= place(w_dq.ctx.cy, w_dq.neg[3], w_dq.q[3], w_dq.over[3]);
        end
    end

    // stage G: distance components
    logic signed [32:0]     w_dd [LANES];
    logic                   r_g_v;
    t_ctx                   r_g_ctx;
    logic signed [31:0]     r_g_x1, r_g_y1, r_g_x2, r_g_y2;
    logic [LANES-1:0][32:0] r_g_abs;

    assign w_dd[0] = {r_f_ctx.px[31], r_f_ctx.px} - {r_f_x1[31], r_f_x1};
    assign w_dd[1] = {r_f_ctx.py[31], r_f_ctx.py} - {r_f_y1[31], r_f_y1};
    assign w_dd[2] = {r_f_ctx.px[31], r_f_ctx.px} - {r_f_x2[31], r_f_x2};
    assign w_dd[3] = {r_f_ctx.py[31], r_f_ctx.py} - {r_f_y2[31], r_f_y2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (w_en) begin
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_ctx <= r_f_ctx;
            r_g_x1  <= r_f_x1;
            r_g_y1  <= r_f_y1;
            r_g_x2  <= r_f_x2;
            r_g_y2  <= r_f_y2;
            for (int l = 0; l < LANES; l++) begin
                r_g_abs[l] <= w_dd[l][32] ? 33'(-w_dd[l]) : 33'(w_dd[l]);
            end
        end
    end

    // stage H: squares
    logic                   r_h_v;
    t_ctx                   r_h_ctx;
    logic signed [31:0]     r_h_x1, r_h_y1, r_h_x2, r_h_y2;
    logic [LANES-1:0][65:0] r_h_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (w_en) begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_ctx <= r_g_ctx;
            r_h_x1  <= r_g_x1;
            r_h_y1  <= r_g_y1;
            r_h_x2  <= r_g_x2;
            r_h_y2  <= r_g_y2;
            for (int l = 0; l < LANES; l++) begin
                r_h_sq[l] <= {33'b0, r_g_abs[l]} * {33'b0, r_g_abs[l]};
            end
        end
    end

    // output stage: compare and select
    logic [66:0] w_dist1, w_dist2;
    logic        w_pick1;

    assign w_dist1 = {1'b0, r_h_sq[0]} + {1'b0, r_h_sq[1]};
    assign w_dist2 = {1'b0, r_h_sq[2]} + {1'b0, r_h_sq[3]};
    assign w_pick1 = w_dist2 > w_dist1;

    logic               r_out_v;
    logic signed [31:0] r_out_x, r_out_y;
    logic               r_out_inside, r_out_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_h_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_inside <= r_h_ctx.in_circle;
            r_out_center <= r_h_ctx.at_center;
            priority if (r_h_ctx.at_center) begin
                r_out_x <= r_h_ctx.cx;
                r_out_y <= r_h_ctx.cy;
            end else if (w_pick1) begin
                r_out_x <= r_h_x1;
                r_out_y <= r_h_y1;
            end else begin
                r_out_x <= r_h_x2;
                r_out_y <= r_h_y2;
            end
        end
    end

    assign w_en              = !r_out_v || i_out_ready;
    assign o_in_ready        = w_en;
    assign o_out_valid       = r_out_v;
    assign o_tangent_x       = r_out_x;
    assign o_tangent_y       = r_out_y;
    assign o_start_inside    = r_out_inside;
    assign o_start_at_center = r_out_center;
endmodule

### sim/circle_tangent_point_select_tb.sv
// Testbench for circle_tangent_point_select: directed table plus random geometry, predictor-checked.
module circle_tangent_point_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 830;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 200;

    typedef struct {
        logic signed [31:0] sx, sy, cx, cy;
        logic        [30:0] r;
        logic signed [31:0] px, py;
    } t_query;

    typedef struct {
        logic signed [31:0] tx, ty;
        logic               in_circle, at_center;
    } t_tangent;

    typedef struct {
        t_query   q;
        bit       typed;
        t_tangent t;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_start_x, i_start_y, i_center_x, i_center_y;
    logic        [30:0] i_circle_radius;
    logic signed [31:0] i_ref_x, i_ref_y;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_tangent_x, o_tangent_y;
    logic               o_start_inside, o_start_at_center;

    circle_tangent_point_select DUT (.*);

    t_tangent expected_tangents[$];
    t_row     rows[$];
    int       n_fail;
    int       idle_cycles;
    bit       stim_done;
    bit       quiet_in, quiet_out;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] place_coord(logic signed [31:0] c,
            logic signed [129:0] num, logic signed [129:0] den);
        logic signed [129:0] quo;
        logic signed [129:0] v;
        quo = num / den;
        if (quo > 130'sd8589934592) quo = 130'sd8589934592;
        if (quo < -130'sd8589934592) quo = -130'sd8589934592;
        v = quo + c;
        if (v > 130'sd2147483647) v = 130'sd2147483647;
        if (v < -130'sd2147483648) v = -130'sd2147483648;
        return v[31:0];
    endfunction

    function automatic logic [129:0] sq_dist(logic signed [31:0] px, logic signed [31:0] py,
            logic signed [31:0] tx, logic signed [31:0] ty);
        logic signed [129:0] dx, dy;
        dx = px - tx;
        dy = py - ty;
        return dx * dx + dy * dy;
    endfunction

    function automatic t_tangent predict_tangent(t_query q);
        t_tangent t;
        logic signed [129:0] x, y, d, r, r2, k, rem, bitv;
        logic signed [31:0] x1, y1, x2, y2;
        x = q.sx - q.cx;
        y = q.sy - q.cy;
        d = x * x + y * y;
        r = q.r;
        r2 = r * r;
        t.in_circle = d < r2;
        t.at_center = (x == 0) && (y == 0);
        if (t.at_center) begin
            t.tx = q.cx;
            t.ty = q.cy;
            return t;
        end
        k = 0;
        if (!t.in_circle) begin
            rem = d - r2;
            for (int b = 33; b >= 0; b--) begin
                bitv = k + (130'sd1 <<< b);
                if (bitv * bitv <= rem) k = bitv;
            end
        end
        x1 = place_coord(q.cx, r2 * x + r * y * k, d);
        y1 = place_coord(q.cy, r2 * y - r * x * k, d);
        x2 = place_coord(q.cx, r2 * x - r * y * k, d);
        y2 = place_coord(q.cy, r2 * y + r * x * k, d);
        if (sq_dist(q.px, q.py, x2, y2) > sq_dist(q.px, q.py, x1, y1)) begin
            t.tx = x1;
            t.ty = y1;
        end else begin
            t.tx = x2;
            t.ty = y2;
        end
        return t;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 4000)) - 2000;
            2: return ($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2) mode = 0;
        else if (mode < 5) mode = 1;
        else if (mode < 9) mode = 2;
        else mode = 3;
        q.cx = rand_coord(mode);
        q.cy = rand_coord(mode);
        q.sx = rand_coord(mode);
        q.sy = rand_coord(mode);
        q.px = rand_coord(mode);
        q.py = rand_coord(mode);
        case ($urandom_range(0, 5))
            0: q.r = 31'($urandom);
            1: q.r = 31'($urandom_range(0, 3000));
            2: q.r = 31'($urandom_range(0, 1000) << 16);
            default: q.r = 31'($urandom_range(0, 600) << 16);
        endcase
        if ($urandom_range(0, 19) == 0) begin
            q.sx = q.cx;
            q.sy = q.cy;
        end
        return q;
    endfunction

    function automatic t_row mk_row(logic signed [31:0] sx, logic signed [31:0] sy,
            logic signed [31:0] cx, logic signed [31:0] cy, logic [30:0] r,
            logic signed [31:0] px, logic signed [31:0] py, bit typed,
            logic signed [31:0] tx, logic signed [31:0] ty, logic ins, logic atc);
        t_row w;
        w.q = '{sx, sy, cx, cy, r, px, py};
        w.typed = typed;
        w.t = '{tx, ty, ins, atc};
        return w;
    endfunction

    task automatic send_query(t_query q, t_tangent t);
        i_in_valid      <= 1'b1;
        i_start_x       <= q.sx;
        i_start_y       <= q.sy;
        i_center_x      <= q.cx;
        i_center_y      <= q.cy;
        i_circle_radius <= q.r;
        i_ref_x         <= q.px;
        i_ref_y         <= q.py;
        do @(posedge i_clk); while (!o_in_ready);
        expected_tangents.push_back(t);
    endtask

    task automatic send_gap();
        if (!quiet_in && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stimulus
    initial begin
        t_query q;
        t_tangent t;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        {i_start_x, i_start_y, i_center_x, i_center_y, i_ref_x, i_ref_y} = '0;
        i_circle_radius = '0;
        stim_done = 0;
        quiet_in = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
        rows.push_back(mk_row(5, -7, 5, -7, 100, 0, 0, 1, 5, -7, 1, 1));
        rows.push_back(mk_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
            31'h7fffffff, 0, 0, 1, 32'sh7fffffff, 32'sh80000000, 1, 1));
        rows.push_back(mk_row(100, 0, 0, 0, 100, 0, 0, 1, 100, 0, 0, 0));
        rows.push_back(mk_row(300, 400, 7, 9, 0, 1, 1, 1, 7, 9, 0, 0));
        rows.push_back(mk_row(200 <<< 16, 0, 0, 0, 100 <<< 16, 0, 50 <<< 16, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(200 <<< 16, 0, 0, 0, 100 <<< 16, 0, -50 <<< 16, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(200 <<< 16, 0, 0, 0, 100 <<< 16, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(10, 0, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(-3, 4, 1, -1, 1000, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(1, 0, 0, 0, 31'h7fffffff, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
            31'h7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
            31'h7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(32'sh80000000, 0, 32'sh7fffffff, 0, 1, -1, -1, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(0, 32'sh7fffffff, 0, 32'sh80000000, 31'h40000000,
            32'sh7fffffff, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(-1, -1, 1, 1, 2, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(3, 0, 0, 4, 5, 0, 0, 0, 0, 0, 0, 0));

        foreach (rows[i]) begin
            t = rows[i].typed ? rows[i].t : predict_tangent(rows[i].q);
            send_query(rows[i].q, t);
            send_gap();
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet_in = (n >= 300 && n < 450);
            q = rand_query();
            send_query(q, predict_tangent(q));
            send_gap();
        end
        i_in_valid <= 1'b0;
        stim_done = 1;
    end

    // Output backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            quiet_out <= stim_done ? quiet_out : ($urandom_range(0, 999) == 0 ? ~quiet_out
                                                                                : quiet_out);
            i_out_ready <= quiet_out || ($urandom_range(0, 99) >= 30);
        end
    end

    // Result check
    always @(posedge i_clk) begin
        t_tangent e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tangents.size() == 0) begin
                $error("unexpected transaction: tangent_x %0d tangent_y %0d",
                    o_tangent_x, o_tangent_y);
                n_fail++;
            end else begin
                e = expected_tangents.pop_front();
                if (o_tangent_x !== e.tx) begin
                    $error("tangent_x expected %0d actual %0d", e.tx, o_tangent_x);
                    n_fail++;
                end
                if (o_tangent_y !== e.ty) begin
                    $error("tangent_y expected %0d actual %0d", e.ty, o_tangent_y);
                    n_fail++;
                end
                if (o_start_inside !== e.in_circle) begin
                    $error("start_inside expected %0b actual %0b", e.in_circle, o_start_inside);
                    n_fail++;
                end
                if (o_start_at_center !== e.at_center) begin
                    $error("start_at_center expected %0b actual %0b",
                        e.at_center, o_start_at_center);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && idle_cycles >= IDLE_LIMIT) begin
            $display("circle_tangent_point_select_tb: errors");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (expected_tangents.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("circle_tangent_point_select_tb: clean");
        end else begin
            $display("circle_tangent_point_select_tb: errors");
        end
        $finish;
    end

endmodule

### circle_tangent_point_select.f
design/ctps_pkg.sv
design/ctps_mul.sv
design/ctps_sqrt_cell.sv
design/ctps_div_cell.sv
design/circle_tangent_point_select.sv
sim/circle_tangent_point_select_tb.sv
